FILE: hw/rtl/xor_frame_checker_unit_assert.svh
// assertion macros for the frame checker rtl
// no dependencies; include with the bare file name
`ifndef XOR_FRAME_CHECKER_UNIT_ASSERT_SVH
`define XOR_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define XFC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/xfc_pkg.sv
// types and constants for the xor frame checker
// no dependencies
package xfc_pkg;

	localparam logic [7:0] HEAD_CODE = 8'h01;
	localparam logic [7:0] ETX_CODE = 8'h03;
	localparam logic [7:0] CMD_RESET = 8'h01;
	localparam logic [16:0] SIZE_OVERHEAD = 17'd6;

	localparam logic [2:0] VERDICT_OK = 3'd0;
	localparam logic [2:0] VERDICT_CHECKSUM = 3'd1;
	localparam logic [2:0] VERDICT_ETX = 3'd2;
	localparam logic [2:0] VERDICT_HEAD = 3'd3;
	localparam logic [2:0] VERDICT_CMD = 3'd4;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		KIND_HEAD,
		KIND_CMD,
		KIND_BODY,
		KIND_ETX,
		KIND_LAST
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t kind;
		logic [16:0] size;
	} entry_t;

endpackage

FILE: hw/rtl/xfc_queue.sv
// two-entry queue between the byte classifier and the checker
// depends on xfc_pkg and xor_frame_checker_unit_assert.svh
`include "xor_frame_checker_unit_assert.svh"
module xfc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xfc_pkg::entry_t push_entry,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output xfc_pkg::entry_t head_entry
);
	import xfc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return PTR_W'(ptr + PTR_W'(1));
	endfunction

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + CNT_W'(1));
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - CNT_W'(1));
			end
		end
	end

	`XFC_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !full, "push into full queue")
	`XFC_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from empty queue")
	`XFC_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !empty, "pushed entry lost")

endmodule

FILE: hw/rtl/xfc_front.sv
// byte classifier: tracks frame position and size, tags each byte
// depends on xfc_pkg
module xfc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,
	input  logic            s_tuser,
	output logic            push,
	output xfc_pkg::entry_t push_entry,
	input  logic            full
);
	import xfc_pkg::*;

	logic        in_frame_q;
	logic [16:0] pos_q;
	logic [16:0] size_q;

	logic        accept;
	logic        live;
	logic [16:0] pos_cur;
	logic [16:0] size_cur;
	logic [16:0] size_next;
	logic        frame_done;
	kind_t       kind;

	assign s_tready = !full;
	assign accept = s_tvalid && !full;
	assign live = s_tuser || in_frame_q;
	assign pos_cur = s_tuser ? '0 : pos_q;
	assign size_cur = s_tuser ? '0 : size_q;
	assign push = accept && live;

	always_comb begin
		size_next = size_cur;
		frame_done = 1'b0;
		priority if (pos_cur == 17'd0) begin
			kind = KIND_HEAD;
		end else if (pos_cur == 17'd1) begin
			kind = KIND_CMD;
		end else if (pos_cur == 17'd2) begin
			kind = KIND_BODY;
			size_next = {1'b0, s_tdata, 8'd0};
		end else if (pos_cur == 17'd3) begin
			kind = KIND_BODY;
			size_next = 17'(size_cur + {9'd0, s_tdata} + SIZE_OVERHEAD);
		end else if (pos_cur == 17'(size_cur - 17'd1)) begin
			kind = KIND_LAST;
			frame_done = 1'b1;
		end else if (pos_cur == 17'(size_cur - 17'd2)) begin
			kind = KIND_ETX;
		end else begin
			kind = KIND_BODY;
		end
	end

	assign push_entry = '{data: s_tdata, kind: kind, size: size_cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= '0;
			size_q <= '0;
		end else if (push) begin
			size_q <= size_next;
			if (frame_done) begin
				in_frame_q <= 1'b0;
				pos_q <= '0;
			end else begin
				in_frame_q <= 1'b1;
				pos_q <= 17'(pos_cur + 17'd1);
			end
		end
	end

endmodule

FILE: hw/rtl/xfc_back.sv
// checker: xor accumulation, field capture, verdict and output register
// depends on xfc_pkg
module xfc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wen,
	input  logic [7:0]      cfg_wdata,
	input  logic            empty,
	input  xfc_pkg::entry_t head_entry,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata
);
	import xfc_pkg::*;

	logic [7:0]  exp_cmd_q;
	logic [7:0]  xor_q;
	logic [7:0]  head_q;
	logic [7:0]  cmd_q;
	logic        etx_ok_q;
	logic        out_valid_q;
	logic [2:0]  verdict_q;
	logic [16:0] size_out_q;
	logic [7:0]  cmd_out_q;

	logic        out_free;
	logic        is_last;
	logic        load;
	logic [2:0]  verdict;

	assign out_free = !out_valid_q || m_tready;
	assign is_last = (head_entry.kind == KIND_LAST);
	assign pop = !empty && (!is_last || out_free);
	assign load = pop && is_last;

	always_comb begin
		priority if (head_entry.data != xor_q) begin
			verdict = VERDICT_CHECKSUM;
		end else if (!etx_ok_q) begin
			verdict = VERDICT_ETX;
		end else if (head_q != HEAD_CODE) begin
			verdict = VERDICT_HEAD;
		end else if (cmd_q != exp_cmd_q) begin
			verdict = VERDICT_CMD;
		end else begin
			verdict = VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= CMD_RESET;
			xor_q <= '0;
			head_q <= '0;
			cmd_q <= '0;
			etx_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				exp_cmd_q <= cfg_wdata;
			end
			if (pop) begin
				unique case (head_entry.kind)
					KIND_HEAD: begin
						head_q <= head_entry.data;
						cmd_q <= '0;
						etx_ok_q <= 1'b0;
						xor_q <= head_entry.data;
					end
					KIND_CMD: begin
						cmd_q <= head_entry.data;
						xor_q <= xor_q ^ head_entry.data;
					end
					KIND_BODY: begin
						xor_q <= xor_q ^ head_entry.data;
					end
					KIND_ETX: begin
						etx_ok_q <= (head_entry.data == ETX_CODE);
						xor_q <= xor_q ^ head_entry.data;
					end
					KIND_LAST: begin
					end
					default: begin
					end
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= verdict;
			size_out_q <= head_entry.size;
			cmd_out_q <= cmd_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, cmd_out_q, size_out_q, verdict_q};

endmodule

FILE: hw/rtl/xor_frame_checker_unit.sv
// top level of the xor frame checker
// depends on xfc_pkg, xfc_front, xfc_queue and xfc_back
//
// usage:
// bytes enter on the s_ channel, one per accepted request; s_tuser high marks
// the first byte of a frame and restarts parsing, dropping any open frame.
// bytes outside a frame without s_tuser are taken and discarded.
// a frame is head, command, 16-bit big-endian length, payload, etx, xor byte.
// after the last byte of a frame one result leaves on the m_ channel with the
// verdict (checksum, etx, head, command, in that order), size and command.
// cfg_wen/cfg_wdata set the expected command code; the user must write them only
// while the block is idle, the block does not enforce it. throughput: one byte per
// cycle while s_tready is high; the classifier, the two-entry queue and the checker
// each take a byte every cycle. m_tvalid rises once the checker pops the last byte.
// when m_tready is low the result holds in the output register; the checker
// keeps consuming payload bytes and only waits at the next frame end, where
// the waiting last byte and one more byte fill the queue and drop s_tready.
// reset clears the parser, queue and output; expected command resets to 0x01.
module xor_frame_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // frame_byte
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // verdict[2:0], frame_size[19:3], command_seen[27:20]
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata
);
	import xfc_pkg::*;

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	entry_t push_entry;
	entry_t head_entry;

	xfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	xfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head_entry (head_entry)
	);

	xfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.empty      (empty),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: sim/xfc_verdict_monitor.sv
// watches the byte and result channels of the xor frame checker, predicts each verdict
// and compares it with the result that leaves the block
// depends on xfc_pkg
module xfc_verdict_monitor
	import xfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // frame_byte
	input  logic        s_tuser,   // frame_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // verdict[2:0], frame_size[19:3], command_seen[27:20]
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	output int          err_count,
	output int          open_verdicts
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [16:0] size;
		logic [7:0]  cmd;
	} verdict_t;

	verdict_t    verdict_q[$];
	logic [7:0]  want_cmd;
	logic [16:0] pos;
	logic [16:0] size;
	logic [7:0]  sum;
	logic [7:0]  head;
	logic [7:0]  cmd;
	logic        etx_seen;
	logic        busy;

	task automatic parse_byte(input logic [7:0] b, input logic st);
		verdict_t r;
		if (st) begin
			busy = 1'b1;
			pos = '0;
			size = '0;
			sum = '0;
			head = '0;
			cmd = '0;
			etx_seen = 1'b0;
		end
		if (busy) begin
			case (pos)
				17'd0: head = b;
				17'd1: cmd = b;
				17'd2: size = {1'b0, b, 8'h00};
				17'd3: size = size + {9'd0, b} + SIZE_OVERHEAD;
				default: begin
					if (pos == size - 17'd2)
						etx_seen = (b == ETX_CODE);
					if (pos == size - 17'd1) begin
						if (b != sum)
							r.verdict = VERDICT_CHECKSUM;
						else if (!etx_seen)
							r.verdict = VERDICT_ETX;
						else if (head != HEAD_CODE)
							r.verdict = VERDICT_HEAD;
						else if (cmd != want_cmd)
							r.verdict = VERDICT_CMD;
						else
							r.verdict = VERDICT_OK;
						r.size = size;
						r.cmd = cmd;
						verdict_q.push_back(r);
						busy = 1'b0;
						pos = '0;
					end
				end
			endcase
			if (busy) begin
				sum = sum ^ b;
				pos = pos + 17'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t exp_r;
		if (!arst_n) begin
			want_cmd = CMD_RESET;
			pos = '0;
			size = '0;
			sum = '0;
			head = '0;
			cmd = '0;
			etx_seen = 1'b0;
			busy = 1'b0;
			verdict_q.delete();
			err_count = 0;
			open_verdicts = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected result verdict %0d size %0d cmd %02h",
							$realtime, m_tdata[2:0], m_tdata[19:3], m_tdata[27:20]);
				end else begin
					exp_r = verdict_q.pop_front();
					if (m_tdata[2:0] != exp_r.verdict || m_tdata[19:3] != exp_r.size ||
							m_tdata[27:20] != exp_r.cmd) begin
						err_count++;
						if (err_count <= 10)
							$display("%0t: mismatch verdict %0d/%0d size %0d/%0d cmd %02h/%02h",
								$realtime, exp_r.verdict, m_tdata[2:0], exp_r.size,
								m_tdata[19:3], exp_r.cmd, m_tdata[27:20]);
					end
				end
			end
			if (cfg_wen)
				want_cmd = cfg_wdata;
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser);
			open_verdicts = verdict_q.size();
		end
	end

endmodule

FILE: sim/xor_frame_checker_unit_tb.sv
// stimulus and verdict for the xor frame checker: directed and random frames,
// command register phases and receiver stalls; depends on xfc_pkg, the rtl and
// xfc_verdict_monitor
module xor_frame_checker_unit_tb;
	import xfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WHOLE_FRAME = 1 << 30;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_wen;
	logic [7:0]  cfg_wdata;

	int          err_count;
	int          open_verdicts;
	int          bytes_sent;
	int          quiet_cycles = 0;
	bit          tx_idle_on;
	bit          rx_idle_on;
	bit          hold_req;
	bit          hold_done;
	logic [7:0]  want_cmd;

	always #5 clk = ~clk;

	xor_frame_checker_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	xfc_verdict_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.err_count    (err_count),
		.open_verdicts(open_verdicts)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] head, input logic [7:0] cmd,
			input logic [15:0] len, input logic [7:0] etx, input logic [7:0] flip,
			input int keep);
		int total;
		logic [7:0] acc;
		logic [7:0] b;
		total = int'(len) + 6;
		acc = '0;
		for (int i = 0; i < total && i < keep; i++) begin
			if (i == 0)
				b = head;
			else if (i == 1)
				b = cmd;
			else if (i == 2)
				b = len[15:8];
			else if (i == 3)
				b = len[7:0];
			else if (i == total - 2)
				b = etx;
			else if (i == total - 1)
				b = acc ^ flip;
			else
				b = 8'($urandom);
			send_byte(b, i == 0);
			acc = acc ^ b;
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (open_verdicts != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_cmd(input logic [7:0] v);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		want_cmd = v;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin : rx
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			gap = rx_idle_on ? $urandom_range(0, 3) : 0;
			repeat (gap) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				rx_idle_on = !rx_idle_on;
		end
	end

	initial begin : stim
		int target;
		int r;
		int keep;
		logic [15:0] len;
		logic [7:0] head;
		logic [7:0] cmd;
		logic [7:0] etx;
		logic [7:0] flip;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req = 1'b0;
		hold_done = 1'b0;
		want_cmd = CMD_RESET;
		bytes_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames while the expected command is the reset code
		send_frame(HEAD_CODE, CMD_RESET, 16'd0, ETX_CODE, 8'h00, WHOLE_FRAME);
		send_frame(HEAD_CODE, CMD_RESET, 16'd3, ETX_CODE, 8'hFF, WHOLE_FRAME);
		send_frame(HEAD_CODE, CMD_RESET, 16'd1, 8'h00, 8'h00, WHOLE_FRAME);
		send_frame(8'hFF, CMD_RESET, 16'd0, ETX_CODE, 8'h00, WHOLE_FRAME);
		send_frame(HEAD_CODE, 8'h00, 16'd2, ETX_CODE, 8'h00, WHOLE_FRAME);
		send_frame(8'h00, 8'hFE, 16'd0, 8'hFF, 8'h01, WHOLE_FRAME);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_frame(HEAD_CODE, CMD_RESET, 16'd4, ETX_CODE, 8'h00, 3);
		send_frame(HEAD_CODE, CMD_RESET, 16'd4, ETX_CODE, 8'h00, 8);
		send_frame(HEAD_CODE, CMD_RESET, 16'd1, ETX_CODE, 8'h00, WHOLE_FRAME);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_cmd(8'hFF);
				1: set_cmd(8'h00);
				2: set_cmd(8'($urandom));
				default: set_cmd(CMD_RESET);
			endcase
			if (ph == 1) begin
				// receiver holds off while short frames keep coming
				tx_idle_on = 1'b0;
				hold_req = 1'b1;
				repeat (16)
					send_frame(HEAD_CODE, want_cmd, 16'($urandom_range(0, 4)), ETX_CODE,
						8'h00, WHOLE_FRAME);
				tx_idle_on = 1'b1;
			end
			target = bytes_sent + 90;
			while (bytes_sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					repeat ($urandom_range(1, 3))
						send_byte(8'($urandom), 1'b0);
				end else begin
					len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 300)) :
						16'($urandom_range(0, 10));
					head = HEAD_CODE;
					cmd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : want_cmd;
					etx = ETX_CODE;
					flip = 8'h00;
					keep = WHOLE_FRAME;
					case ($urandom_range(0, 11))
						0: flip = 8'($urandom_range(1, 255));
						1: etx = 8'($urandom);
						2: head = 8'($urandom);
						3: begin
							head = 8'($urandom);
							etx = 8'($urandom);
							flip = 8'($urandom);
						end
						4, 5: keep = $urandom_range(1, int'(len) + 5);
						default: ;
					endcase
					send_frame(head, cmd, len, etx, flip, keep);
				end
				if ($urandom_range(0, 7) == 0)
					tx_idle_on = !tx_idle_on;
			end
		end

		// largest length field, cut short by a new frame, sent back to back
		tx_idle_on = 1'b0;
		send_frame(HEAD_CODE, want_cmd, 16'hFFFF, ETX_CODE, 8'h00, 40);
		send_frame(HEAD_CODE, want_cmd, 16'd2, ETX_CODE, 8'h00, WHOLE_FRAME);

		wait_idle();
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
